// ===== design/piq_pkg.sv =====
// types, register codes and reset values shared by the poll qualifier
`timescale 1ns / 1ps
package piq_pkg;

  // configuration register indexes
  localparam logic [1:0] CFG_DEAD_ZONE       = 2'd0;
  localparam logic [1:0] CFG_TRIGGER_THRESH  = 2'd1;
  localparam logic [1:0] CFG_REPEAT_DELAY    = 2'd2;
  localparam logic [1:0] CFG_REPEAT_INTERVAL = 2'd3;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // register values after reset
  localparam logic [6:0]  DEAD_ZONE_RST       = 7'd20;
  localparam logic [7:0]  TRIGGER_THRESH_RST  = 8'd30;
  localparam logic [15:0] REPEAT_DELAY_RST    = 16'd400;
  localparam logic [15:0] REPEAT_INTERVAL_RST = 16'd100;

  // held mask bit positions
  localparam int BIT_UP    = 5;
  localparam int BIT_DOWN  = 6;
  localparam int BIT_LEFT  = 7;
  localparam int BIT_RIGHT = 8;
  localparam int BIT_LTRIG = 9;
  localparam int BIT_RTRIG = 10;
  localparam int MASK_W    = 11;

  typedef struct packed {
    logic               controller_present;
    logic               status_valid;
    logic [8:0]         raw_buttons;
    logic signed [7:0]  stick_horizontal;
    logic signed [7:0]  stick_vertical;
    logic [7:0]         left_trigger_level;
    logic [7:0]         right_trigger_level;
    logic [31:0]        now_ms;
  } piq_in_t;

  typedef struct packed {
    logic [10:0]        buttons_held;
    logic [10:0]        buttons_new;
    logic signed [7:0]  stick_x_filtered;
    logic signed [7:0]  stick_y_filtered;
    logic [7:0]         left_trigger_out;
    logic [7:0]         right_trigger_out;
    logic               any_held;
    logic [31:0]        last_input_ms;
  } piq_out_t;

  typedef struct packed {
    logic [6:0]  stick_dead_zone;
    logic [7:0]  trig_thresh;
    logic [15:0] rpt_delay_ms;
    logic [15:0] repeat_interval_ms;
  } piq_cfg_t;

  typedef struct packed {
    logic [10:0]        held_mask;
    logic signed [7:0]  stick_x;
    logic signed [7:0]  stick_y;
    logic [7:0]         left_trigger;
    logic [7:0]         right_trigger;
    logic [3:0]         repeat_direction;
    logic [31:0]        repeat_start_ms;
    logic [31:0]        repeat_last_ms;
    logic [31:0]        input_seen_ms;
  } piq_state_t;

endpackage

// ===== design/pad_input_repeat_qualifier_unit.sv =====
// top level of the controller poll qualifier: handshakes, config and state
`timescale 1ns / 1ps
// Controller poll qualifier.
// in_valid / in_stall / in_data carry one poll request per accept; the
// block answers each with exactly one result request on out_valid /
// out_stall / out_data, in order.
// Pipeline: an input register, one pass of qualify logic, a result
// register; a poll reaches out_valid through both registers. Throughput
// is one poll per cycle unless out_stall holds a full result; the pass
// reads and writes poll state (held mask, axes, triggers, repeat timers).
// When out_stall is high and the result register is full, a poll in
// the input register is held and in_stall rises in the same cycle; a
// free result slot lets the next poll in even while the previous result
// is still being taken.
// cfg_valid / cfg_ready / cfg_index / cfg_wdata write the four registers
// (dead zone, trigger threshold, repeat delay, repeat interval); cfg_ready
// is always high. Write them only while no poll is in flight.
// Synchronous reset (rst_n low) empties both stages, zeroes the poll state
// and loads the register defaults (20, 30, 400 ms, 100 ms).
module pad_input_repeat_qualifier_unit
  import piq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  piq_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output piq_out_t              out_data,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  // stage registers
  logic       s1_valid_r;
  logic       s1_valid_nxt;
  piq_in_t    s1_data_r;
  logic       out_valid_r;
  logic       out_valid_nxt;
  piq_out_t   out_data_r;

  // poll state and configuration
  piq_state_t state_r;
  piq_state_t state_nxt;
  piq_cfg_t   cfg_r;
  piq_cfg_t   cfg_nxt;
  piq_out_t   res;

  logic out_free;
  logic s1_adv;
  logic in_take;

  // result slot can take a new value when empty or being drained
  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;
  assign in_take  = in_valid && !in_stall;

  assign s1_valid_nxt  = in_take || (s1_valid_r && !s1_adv);
  assign out_valid_nxt = s1_adv || (out_valid_r && out_stall);

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  piq_qualify u_qualify (
    .poll (s1_data_r),
    .cfg  (cfg_r),
    .cur  (state_r),
    .nxt  (state_nxt),
    .res  (res)
  );

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_DEAD_ZONE:       cfg_nxt.stick_dead_zone    = cfg_wdata[6:0];
        CFG_TRIGGER_THRESH:  cfg_nxt.trig_thresh        = cfg_wdata[7:0];
        CFG_REPEAT_DELAY:    cfg_nxt.rpt_delay_ms       = cfg_wdata;
        CFG_REPEAT_INTERVAL: cfg_nxt.repeat_interval_ms = cfg_wdata;
        default:             cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r                  <= 1'b0;
      out_valid_r                 <= 1'b0;
      state_r                     <= '0;
      cfg_r.stick_dead_zone       <= DEAD_ZONE_RST;
      cfg_r.trig_thresh           <= TRIGGER_THRESH_RST;
      cfg_r.rpt_delay_ms          <= REPEAT_DELAY_RST;
      cfg_r.repeat_interval_ms    <= REPEAT_INTERVAL_RST;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      cfg_r       <= cfg_nxt;
      // state commits as the poll moves into the result slot
      if (s1_adv) state_r <= state_nxt;
    end
  end

  // payload registers, no reset
  always_ff @(posedge clk) begin
    if (in_take) s1_data_r <= in_data;
    if (s1_adv)  out_data_r <= res;
  end

  // repeat direction always tracks the held d-pad bits
  assert property (@(posedge clk) disable iff (!rst_n)
    state_r.repeat_direction == state_r.held_mask[BIT_RIGHT:BIT_UP])
    else $error("repeat direction out of step with held d-pad bits");

  // new presses are always a subset of the held bits
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_data_r.buttons_new & ~out_data_r.buttons_held) == '0))
    else $error("new button bit not held");

  // a result only appears after a poll sat in the input register
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result without a poll");

  // backpressure only when the input register is occupied
  assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r))
    else $error("input stalled with free pipeline");

endmodule

// ===== design/piq_qualify.sv =====
// one poll: mask build, edge detect, auto repeat and dead-zoned axes
`timescale 1ns / 1ps
module piq_qualify
  import piq_pkg::*;
(
  input  piq_in_t    poll,
  input  piq_cfg_t   cfg,
  input  piq_state_t cur,
  output piq_state_t nxt,
  output piq_out_t   res
);

  logic signed [8:0] dz_pos;
  logic signed [8:0] dz_neg;
  logic signed [8:0] sx9;
  logic signed [8:0] sy9;
  logic [10:0]       mask;
  logic [10:0]       fresh;
  logic [3:0]        dir;
  logic [31:0]       since_start;
  logic [31:0]       since_last;
  logic [8:0]        mag_x;
  logic [8:0]        mag_y;

  always_comb begin
    nxt    = cur;
    dz_pos = $signed({2'b00, cfg.stick_dead_zone});
    dz_neg = -dz_pos;
    sx9    = {poll.stick_horizontal[7], poll.stick_horizontal};
    sy9    = {poll.stick_vertical[7], poll.stick_vertical};

    mask = {2'b00, poll.raw_buttons};
    if (sy9 < dz_neg) mask[BIT_UP]    = 1'b1;
    if (sy9 > dz_pos) mask[BIT_DOWN]  = 1'b1;
    if (sx9 < dz_neg) mask[BIT_LEFT]  = 1'b1;
    if (sx9 > dz_pos) mask[BIT_RIGHT] = 1'b1;
    if (poll.left_trigger_level  > cfg.trig_thresh) mask[BIT_LTRIG] = 1'b1;
    if (poll.right_trigger_level > cfg.trig_thresh) mask[BIT_RTRIG] = 1'b1;

    if (!poll.controller_present) begin
      nxt.held_mask     = '0;
      nxt.stick_x       = '0;
      nxt.stick_y       = '0;
      nxt.left_trigger  = '0;
      nxt.right_trigger = '0;
    end else if (poll.status_valid) begin
      nxt.held_mask     = mask;
      nxt.stick_x       = poll.stick_horizontal;
      nxt.stick_y       = poll.stick_vertical;
      nxt.left_trigger  = poll.left_trigger_level;
      nxt.right_trigger = poll.right_trigger_level;
    end

    fresh       = nxt.held_mask & ~cur.held_mask;
    dir         = nxt.held_mask[BIT_RIGHT:BIT_UP];
    since_start = poll.now_ms - cur.repeat_start_ms;
    since_last  = poll.now_ms - cur.repeat_last_ms;

    // auto repeat on a steady nonzero d-pad combination
    if (dir != 4'd0) begin
      if (dir != cur.repeat_direction) begin
        nxt.repeat_direction = dir;
        nxt.repeat_start_ms  = poll.now_ms;
        nxt.repeat_last_ms   = poll.now_ms;
      end else if (since_start > {16'd0, cfg.rpt_delay_ms} &&
                   since_last  > {16'd0, cfg.repeat_interval_ms}) begin
        fresh[BIT_RIGHT:BIT_UP] = fresh[BIT_RIGHT:BIT_UP] | dir;
        nxt.repeat_last_ms      = poll.now_ms;
      end
    end else begin
      nxt.repeat_direction = 4'd0;
    end

    if (nxt.held_mask != '0) nxt.input_seen_ms = poll.now_ms;

    // magnitudes reach 128 for the most negative value
    mag_x = nxt.stick_x[7] ? 9'(-$signed({1'b1, nxt.stick_x})) : {1'b0, nxt.stick_x};
    mag_y = nxt.stick_y[7] ? 9'(-$signed({1'b1, nxt.stick_y})) : {1'b0, nxt.stick_y};

    res.buttons_held      = nxt.held_mask;
    res.buttons_new       = fresh;
    res.stick_x_filtered  = (mag_x < {2'b00, cfg.stick_dead_zone}) ? 8'sd0 : nxt.stick_x;
    res.stick_y_filtered  = (mag_y < {2'b00, cfg.stick_dead_zone}) ? 8'sd0 : nxt.stick_y;
    res.left_trigger_out  = nxt.left_trigger;
    res.right_trigger_out = nxt.right_trigger;
    res.any_held          = (nxt.held_mask != '0);
    res.last_input_ms     = nxt.input_seen_ms;
  end

endmodule
